// ===== rtl/dpb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_pkg: shared constants and types of the depth back-projection block
// Register map, reset values, field widths and the configuration groups that
// the front and back parts of the block read.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // largest image side the raster counters cover
  localparam int MAX_DIM_DEFAULT = 4096;
  // entries of the job queue between front and back, a power of two
  localparam int QUEUE_DEPTH     = 2;

  // field widths
  localparam int DEPTH_W    = 16;
  localparam int COORD_W    = 32;
  localparam int SIZE_REG_W = 13;
  localparam int STEP_W     = 7;
  localparam int PARAM_W    = 16;
  localparam int FRAC_W     = 4;

  // stream and configuration port widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 2 * COORD_W + DEPTH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd6;

  // register reset values
  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIZE_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [STEP_W-1:0]     RST_SAMPLE_STEP  = 7'd8;
  localparam logic [PARAM_W-1:0]    RST_FOCAL_X      = 16'd9600;
  localparam logic [PARAM_W-1:0]    RST_FOCAL_Y      = 16'd9600;
  localparam logic [PARAM_W-1:0]    RST_CENTER_X     = 16'd5120;
  localparam logic [PARAM_W-1:0]    RST_CENTER_Y     = 16'd3840;

  // raster geometry seen by the front
  typedef struct packed {
    logic [SIZE_REG_W-1:0] image_width;
    logic [SIZE_REG_W-1:0] image_height;
    logic [STEP_W-1:0]     sample_step;
  } front_cfg_t;

  // camera intrinsics seen by the back
  typedef struct packed {
    logic [PARAM_W-1:0] focal_x;
    logic [PARAM_W-1:0] focal_y;
    logic [PARAM_W-1:0] center_x;
    logic [PARAM_W-1:0] center_y;
  } back_cfg_t;

endpackage

// ===== rtl/depth_pixel_backprojection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_top: depth pixels to 3-D points
// Tracks the raster position of a depth stream and emits one pinhole
// back-projected point for every sampled pixel with non-zero depth.
//
//   channel   direction  transfer condition        payload
//   in_*      slave      in_tvalid & in_tready     depth_mm
//   out_*     master     out_tvalid & out_tready   x_pos, y_pos, z_mm
//   cfg_*     write      cfg_we                    register cfg_index
//
// A pixel that yields no point is taken while the job queue has room and no
// phase resync runs. A point passes through the multiply, the 36-bit restoring
// division at the default size at one quotient bit per cycle and saturation in
// the back part, then waits until its result is taken. Reset is synchronous and
// clears counters, queue and registers. A write of sample_step holds off input
// while the sampling phases are recomputed bit-serially. The front stalls on a
// full queue and during the resync; the back stalls only on out_tready.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_top
  import dpb_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] depth_mm
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] x_pos, [63:32] y_pos, [79:64] z_mm
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int JOB_W = DEPTH_W + 2 * CNT_W;

  front_cfg_t front_cfg_r;
  back_cfg_t  back_cfg_r;
  logic       step_load;

  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [DEPTH_W-1:0] push_depth;
  logic [CNT_W-1:0]   push_col, push_row;
  logic [JOB_W-1:0]   push_data, pop_data;
  logic [COORD_W-1:0] pt_x, pt_y;
  logic [DEPTH_W-1:0] pt_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_cfg_r.image_width  <= RST_IMAGE_WIDTH;
      front_cfg_r.image_height <= RST_IMAGE_HEIGHT;
      front_cfg_r.sample_step  <= RST_SAMPLE_STEP;
      back_cfg_r.focal_x       <= RST_FOCAL_X;
      back_cfg_r.focal_y       <= RST_FOCAL_Y;
      back_cfg_r.center_x      <= RST_CENTER_X;
      back_cfg_r.center_y      <= RST_CENTER_Y;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  front_cfg_r.image_width  <= cfg_wdata[SIZE_REG_W-1:0];
        REG_IMAGE_HEIGHT: front_cfg_r.image_height <= cfg_wdata[SIZE_REG_W-1:0];
        REG_SAMPLE_STEP:  front_cfg_r.sample_step  <= cfg_wdata[STEP_W-1:0];
        REG_FOCAL_X:      back_cfg_r.focal_x       <= cfg_wdata[PARAM_W-1:0];
        REG_FOCAL_Y:      back_cfg_r.focal_y       <= cfg_wdata[PARAM_W-1:0];
        REG_CENTER_X:     back_cfg_r.center_x      <= cfg_wdata[PARAM_W-1:0];
        REG_CENTER_Y:     back_cfg_r.center_y      <= cfg_wdata[PARAM_W-1:0];
        default: ;
      endcase
    end
  end

  // a step write restarts the phase resync
  assign step_load = rst_n && cfg_we && (cfg_index == REG_SAMPLE_STEP);

  dpb_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_depth  (in_tdata[DEPTH_W-1:0]),
    .cfg       (front_cfg_r),
    .step_load (step_load),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_depth(push_depth),
    .push_col  (push_col),
    .push_row  (push_row)
  );

  assign push_data = {push_row, push_col, push_depth};

  dpb_queue #(
    .DATA_W(JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  dpb_back #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (back_cfg_r),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job_depth (pop_data[DEPTH_W-1:0]),
    .job_col   (pop_data[DEPTH_W+CNT_W-1:DEPTH_W]),
    .job_row   (pop_data[JOB_W-1:DEPTH_W+CNT_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (pt_x),
    .out_y     (pt_y),
    .out_z     (pt_z)
  );

  // result packing, first field lowest
  assign out_tdata = {pt_z, pt_y, pt_x};

endmodule

// ===== rtl/dpb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_front: raster tracking and pixel selection
// Keeps column and row counters with their phases modulo the sampling step,
// pushes sampled non-zero pixels into the job queue, and recomputes the
// phases bit-serially after the step register changes.
// ----------------------------------------------------------------------------
module dpb_front
  import dpb_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [DEPTH_W-1:0]               in_depth,
  input  front_cfg_t                       cfg,
  input  logic                             step_load,
  input  logic                             push_ready,
  output logic                             push_valid,
  output logic [DEPTH_W-1:0]               push_depth,
  output logic [$clog2(MAX_DIMENSION)-1:0] push_col,
  output logic [$clog2(MAX_DIMENSION)-1:0] push_row
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int SZ_W  = (CNT_W + 1 > SIZE_REG_W) ? CNT_W + 1 : SIZE_REG_W;
  localparam int IDX_W = $clog2(CNT_W);

  logic [CNT_W-1:0]  col_r, row_r;
  logic [STEP_W-1:0] col_ph_r, row_ph_r;
  logic              busy_r;
  logic [IDX_W-1:0]  sweep_idx_r;
  logic [STEP_W-1:0] rem_col_r, rem_row_r;
  logic [STEP_W-1:0] rem_col_nxt, rem_row_nxt;

  logic [SZ_W-1:0]   w_raw, h_raw, w_eff, h_eff;
  logic [SZ_W-1:0]   col_p1, row_p1;
  logic [STEP_W-1:0] step_eff;
  logic [STEP_W:0]   shift_col, shift_row;
  logic              accept, hit;

  // effective geometry: zero means one, oversize clamps to the counter range
  assign w_raw    = SZ_W'(cfg.image_width);
  assign h_raw    = SZ_W'(cfg.image_height);
  assign w_eff    = (w_raw == '0) ? SZ_W'(1) :
                    (w_raw > SZ_W'(MAX_DIMENSION)) ? SZ_W'(MAX_DIMENSION) : w_raw;
  assign h_eff    = (h_raw == '0) ? SZ_W'(1) :
                    (h_raw > SZ_W'(MAX_DIMENSION)) ? SZ_W'(MAX_DIMENSION) : h_raw;
  assign step_eff = (cfg.sample_step == '0) ? STEP_W'(1) : cfg.sample_step;

  assign col_p1 = SZ_W'(col_r) + SZ_W'(1);
  assign row_p1 = SZ_W'(row_r) + SZ_W'(1);

  // handshake and pixel selection
  assign in_ready   = !busy_r && push_ready;
  assign accept     = in_valid && in_ready;
  assign hit        = (in_depth != '0) && (col_ph_r == '0) && (row_ph_r == '0);
  assign push_valid = accept && hit;
  assign push_depth = in_depth;
  assign push_col   = col_r;
  assign push_row   = row_r;

  // one bit of restoring remainder per cycle for both counters
  always_comb begin
    shift_col = {rem_col_r, col_r[sweep_idx_r]};
    shift_row = {rem_row_r, row_r[sweep_idx_r]};
    if (shift_col >= {1'b0, step_eff}) begin
      rem_col_nxt = STEP_W'(shift_col - {1'b0, step_eff});
    end else begin
      rem_col_nxt = STEP_W'(shift_col);
    end
    if (shift_row >= {1'b0, step_eff}) begin
      rem_row_nxt = STEP_W'(shift_row - {1'b0, step_eff});
    end else begin
      rem_row_nxt = STEP_W'(shift_row);
    end
  end

  // phase resync after a step write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      sweep_idx_r <= '0;
      rem_col_r   <= '0;
      rem_row_r   <= '0;
    end else if (step_load) begin
      busy_r      <= 1'b1;
      sweep_idx_r <= IDX_W'(CNT_W - 1);
      rem_col_r   <= '0;
      rem_row_r   <= '0;
    end else if (busy_r) begin
      rem_col_r   <= rem_col_nxt;
      rem_row_r   <= rem_row_nxt;
      sweep_idx_r <= sweep_idx_r - IDX_W'(1);
      if (sweep_idx_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  // raster counters and their phases
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      col_ph_r <= '0;
      row_ph_r <= '0;
    end else if (busy_r && !step_load && sweep_idx_r == '0) begin
      col_ph_r <= rem_col_nxt;
      row_ph_r <= rem_row_nxt;
    end else if (accept) begin
      if (col_p1 >= w_eff) begin
        col_r    <= '0;
        col_ph_r <= '0;
        if (row_p1 >= h_eff) begin
          row_r    <= '0;
          row_ph_r <= '0;
        end else begin
          row_r    <= CNT_W'(row_p1);
          row_ph_r <= (row_ph_r + STEP_W'(1) == step_eff) ? '0 : row_ph_r + STEP_W'(1);
        end
      end else begin
        col_r    <= CNT_W'(col_p1);
        col_ph_r <= (col_ph_r + STEP_W'(1) == step_eff) ? '0 : col_ph_r + STEP_W'(1);
      end
    end
  end

endmodule

// ===== rtl/dpb_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_queue: small job queue between front and back
// Register-based first-in first-out buffer; push when not full, pop when
// not empty, both in the same cycle allowed.
// ----------------------------------------------------------------------------
module dpb_queue
  import dpb_pkg::*;
#(
  parameter int DATA_W = 40,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]    count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != (PTR_W + 1)'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== rtl/dpb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_back: pinhole projection of one sampled pixel
// Forms the offset magnitudes, multiplies by depth, then divides by the
// focal lengths with two restoring dividers at one quotient bit per cycle,
// saturates, and holds the point until it is taken.
// ----------------------------------------------------------------------------
module dpb_back
  import dpb_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIM_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  back_cfg_t                        cfg,
  input  logic                             job_valid,
  output logic                             job_ready,
  input  logic [DEPTH_W-1:0]               job_depth,
  input  logic [$clog2(MAX_DIMENSION)-1:0] job_col,
  input  logic [$clog2(MAX_DIMENSION)-1:0] job_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [COORD_W-1:0]               out_x,
  output logic [COORD_W-1:0]               out_y,
  output logic [DEPTH_W-1:0]               out_z
);

  localparam int CNT_W  = $clog2(MAX_DIMENSION);
  localparam int MAG_W  = (CNT_W + FRAC_W > PARAM_W) ? CNT_W + FRAC_W : PARAM_W;
  localparam int PROD_W = MAG_W + DEPTH_W;
  localparam int DV_W   = PROD_W + FRAC_W;
  localparam int BIT_W  = $clog2(DV_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [DEPTH_W-1:0] z_r;
  logic               neg_x_r, neg_y_r;
  logic [MAG_W-1:0]   mag_x_r, mag_y_r;
  logic [DV_W-1:0]    dvd_x_r, dvd_y_r;
  logic [PARAM_W-1:0] rem_x_r, rem_y_r;
  logic [BIT_W-1:0]   bit_cnt_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic [DEPTH_W-1:0] out_z_r;

  logic [MAG_W-1:0]   p16_x, p16_y, cx, cy;
  logic               neg_x, neg_y;
  logic [PROD_W-1:0]  prod_x, prod_y;
  logic [PARAM_W-1:0] foc_x, foc_y;
  logic [PARAM_W:0]   sh_x, sh_y;
  logic               qb_x, qb_y;
  logic [PARAM_W-1:0] rem_x_nxt, rem_y_nxt;

  // clamp a quotient into the signed coordinate range and apply the sign
  function automatic logic [COORD_W-1:0] saturate(input logic neg,
                                                  input logic [DV_W-1:0] q);
    logic hi;
    hi = |q[DV_W-1:COORD_W-1];
    if (neg) begin
      saturate = hi ? {1'b1, {(COORD_W - 1){1'b0}}} : COORD_W'(-q[COORD_W-1:0]);
    end else begin
      saturate = hi ? {1'b0, {(COORD_W - 1){1'b1}}} : q[COORD_W-1:0];
    end
  endfunction

  // signed offset from the principal point, as sign and magnitude
  assign p16_x = MAG_W'({job_col, {FRAC_W{1'b0}}});
  assign p16_y = MAG_W'({job_row, {FRAC_W{1'b0}}});
  assign cx    = MAG_W'(cfg.center_x);
  assign cy    = MAG_W'(cfg.center_y);
  assign neg_x = p16_x < cx;
  assign neg_y = p16_y < cy;

  // magnitude times depth
  assign prod_x = PROD_W'(mag_x_r) * PROD_W'(z_r);
  assign prod_y = PROD_W'(mag_y_r) * PROD_W'(z_r);

  // divisors, zero focal length read as one
  assign foc_x = (cfg.focal_x == '0) ? PARAM_W'(1) : cfg.focal_x;
  assign foc_y = (cfg.focal_y == '0) ? PARAM_W'(1) : cfg.focal_y;

  // one restoring division step per divider
  always_comb begin
    sh_x = {rem_x_r, dvd_x_r[DV_W-1]};
    sh_y = {rem_y_r, dvd_y_r[DV_W-1]};
    qb_x = sh_x >= {1'b0, foc_x};
    qb_y = sh_y >= {1'b0, foc_y};
    rem_x_nxt = qb_x ? PARAM_W'(sh_x - {1'b0, foc_x}) : PARAM_W'(sh_x);
    rem_y_nxt = qb_y ? PARAM_W'(sh_y - {1'b0, foc_y}) : PARAM_W'(sh_y);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (job_valid) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (bit_cnt_r == '0) state_nxt = ST_SAT;
      ST_SAT:  state_nxt = ST_HOLD;
      ST_HOLD: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        z_r     <= job_depth;
        neg_x_r <= neg_x;
        neg_y_r <= neg_y;
        mag_x_r <= neg_x ? cx - p16_x : p16_x - cx;
        mag_y_r <= neg_y ? cy - p16_y : p16_y - cy;
      end
      ST_MUL: begin
        dvd_x_r   <= {prod_x, {FRAC_W{1'b0}}};
        dvd_y_r   <= {prod_y, {FRAC_W{1'b0}}};
        rem_x_r   <= '0;
        rem_y_r   <= '0;
        bit_cnt_r <= BIT_W'(DV_W - 1);
      end
      ST_DIV: begin
        dvd_x_r   <= {dvd_x_r[DV_W-2:0], qb_x};
        dvd_y_r   <= {dvd_y_r[DV_W-2:0], qb_y};
        rem_x_r   <= rem_x_nxt;
        rem_y_r   <= rem_y_nxt;
        bit_cnt_r <= bit_cnt_r - BIT_W'(1);
      end
      ST_SAT: begin
        out_x_r <= saturate(neg_x_r, dvd_x_r);
        out_y_r <= saturate(neg_y_r, dvd_y_r);
        out_z_r <= z_r;
      end
      default: ;
    endcase
  end

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_HOLD);
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

endmodule

// ===== rtl/dpb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_checker: port-level checks of the back-projection block
// Watches the top-level ports for reset, hold-off and result properties.
// ----------------------------------------------------------------------------
module dpb_checker
  import dpb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a point always carries a non-zero depth
  a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:2*COORD_W] != '0)
    else $error("point with zero depth");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a step write holds off input while phases are recomputed
  a_step_holdoff: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == REG_SAMPLE_STEP |=> !in_tready)
    else $error("input taken during phase resync");

endmodule

bind depth_pixel_backprojection_top dpb_checker u_dpb_checker (.*);

// ===== sim/dpb_point_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpb_point_checker: scoreboard for the depth back-projection block
// Watches the pixel, point and register channels, tracks the raster position
// and camera setup on its own, predicts each back-projected point and
// compares every point transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module dpb_point_checker
  import dpb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [15:0] depth_mm
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [31:0] x_pos, [63:32] y_pos, [79:64] z_mm
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_points
);

  typedef struct packed {
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
    logic [DEPTH_W-1:0] z_mm;
  } point_t;

  point_t      expected_points[$];
  front_cfg_t  raster_cfg;
  back_cfg_t   camera_cfg;
  int unsigned col_pos;
  int unsigned row_pos;

  initial begin
    fail_count     = 0;
    pending_points = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // zero size counts as one, oversize is cut to the counter range
  function automatic int unsigned clamp_side(logic [SIZE_REG_W-1:0] side);
    if (side == '0) return 1;
    if (int'(side) > MAX_DIM_DEFAULT) return MAX_DIM_DEFAULT;
    return side;
  endfunction

  // (pos*16 - center) * depth * 16 / focal, truncated toward zero, clamped to 32 bits
  function automatic logic [COORD_W-1:0] back_project(int unsigned pos,
                                                      logic [PARAM_W-1:0] center,
                                                      logic [PARAM_W-1:0] focal,
                                                      logic [DEPTH_W-1:0] depth);
    longint unsigned offs;
    longint unsigned ctr;
    longint unsigned mag;
    longint unsigned quot;
    logic            neg;
    offs = 64'(pos) * 64'd16;
    ctr  = 64'(center);
    neg  = offs < ctr;
    mag  = neg ? ctr - offs : offs - ctr;
    quot = (mag * 64'(depth) * 64'd16) / ((focal == '0) ? 64'd1 : 64'(focal));
    if (neg) return (quot >= 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - quot);
    return (quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
  endfunction

  always @(posedge clk) begin
    point_t      got;
    point_t      want;
    int unsigned step;
    int unsigned w;
    int unsigned h;
    if (!rst_n) begin
      raster_cfg.image_width  = RST_IMAGE_WIDTH;
      raster_cfg.image_height = RST_IMAGE_HEIGHT;
      raster_cfg.sample_step  = RST_SAMPLE_STEP;
      camera_cfg.focal_x      = RST_FOCAL_X;
      camera_cfg.focal_y      = RST_FOCAL_Y;
      camera_cfg.center_x     = RST_CENTER_X;
      camera_cfg.center_y     = RST_CENTER_Y;
      col_pos = 0;
      row_pos = 0;
      expected_points.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  raster_cfg.image_width  = cfg_wdata[SIZE_REG_W-1:0];
          REG_IMAGE_HEIGHT: raster_cfg.image_height = cfg_wdata[SIZE_REG_W-1:0];
          REG_SAMPLE_STEP:  raster_cfg.sample_step  = cfg_wdata[STEP_W-1:0];
          REG_FOCAL_X:      camera_cfg.focal_x      = cfg_wdata;
          REG_FOCAL_Y:      camera_cfg.focal_y      = cfg_wdata;
          REG_CENTER_X:     camera_cfg.center_x     = cfg_wdata;
          REG_CENTER_Y:     camera_cfg.center_y     = cfg_wdata;
          default: ;
        endcase
      end

      // point transfer against the oldest prediction
      if (out_tvalid && out_tready) begin
        got.x_pos = out_tdata[COORD_W-1:0];
        got.y_pos = out_tdata[2*COORD_W-1:COORD_W];
        got.z_mm  = out_tdata[OUT_DATA_W-1:2*COORD_W];
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d",
                                    $signed(got.x_pos), $signed(got.y_pos), got.z_mm));
        end else begin
          want = expected_points.pop_front();
          if (got.x_pos !== want.x_pos)
            report_mismatch($sformatf("x_pos %0d, predicted %0d",
                                      $signed(got.x_pos), $signed(want.x_pos)));
          if (got.y_pos !== want.y_pos)
            report_mismatch($sformatf("y_pos %0d, predicted %0d",
                                      $signed(got.y_pos), $signed(want.y_pos)));
          if (got.z_mm !== want.z_mm)
            report_mismatch($sformatf("z_mm %0d, predicted %0d", got.z_mm, want.z_mm));
        end
      end

      // pixel transfer: sample test, projection, raster advance
      if (in_tvalid && in_tready) begin
        step = (raster_cfg.sample_step == '0) ? 1 : raster_cfg.sample_step;
        w    = clamp_side(raster_cfg.image_width);
        h    = clamp_side(raster_cfg.image_height);
        if (in_tdata != '0 && (col_pos % step) == 0 && (row_pos % step) == 0) begin
          want.x_pos = back_project(col_pos, camera_cfg.center_x, camera_cfg.focal_x, in_tdata);
          want.y_pos = back_project(row_pos, camera_cfg.center_y, camera_cfg.focal_y, in_tdata);
          want.z_mm  = in_tdata;
          expected_points = {expected_points, want};
        end
        if (col_pos + 1 >= w) begin
          col_pos = 0;
          row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end else begin
          col_pos = col_pos + 1;
        end
      end
    end
    pending_points = expected_points.size();
  end

endmodule

// ===== sim/tb_depth_pixel_backprojection_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_backprojection_top: stimulus and verdict for the block
// Drives depth pixels and register writes, throttles both stream sides, and
// leaves prediction and comparison to the point checker beside the block.
// ----------------------------------------------------------------------------
module tb_depth_pixel_backprojection_top;
  import dpb_pkg::*;

  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 10000;

  // throttle modes for the two stream sides
  localparam int MODE_RX_SLOW = 0;
  localparam int MODE_TX_SLOW = 1;
  localparam int MODE_FULL    = 2;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [15:0] depth_mm
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [31:0] x_pos, [63:32] y_pos, [79:64] z_mm
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending_points;
  int idle_mode = MODE_RX_SLOW;
  int quiet_cycles = 0;
  bit hold_req = 1'b0;
  int random_sent;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  depth_pixel_backprojection_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  dpb_point_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .pending_points (pending_points)
  );

  // stall watchdog: cycles in a row with no transfer on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_depth_pixel_backprojection_top failed");
      $finish;
    end
  end

  // point receiver: random back-pressure, plus a long hold-off on request
  initial begin : ready_driver
    int hold_left;
    bit hold_seen;
    hold_left  = 0;
    hold_seen  = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (idle_mode)
          MODE_RX_SLOW: out_tready <= ($urandom_range(99) >= 68);
          MODE_TX_SLOW: out_tready <= ($urandom_range(99) >= 21);
          default:      out_tready <= 1'b1;
        endcase
      end
    end
  end

  function automatic bit sender_gap();
    case (idle_mode)
      MODE_RX_SLOW: return $urandom_range(99) < 21;
      MODE_TX_SLOW: return $urandom_range(99) < 68;
      default:      return 1'b0;
    endcase
  endfunction

  // one pixel transfer; valid stays up until the next pixel or an idle cycle
  task automatic send_depth(input logic [DEPTH_W-1:0] depth);
    @(negedge clk);
    while (sender_gap()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= depth;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    random_sent++;
  endtask

  // stop offering pixels and let every pending point drain out
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_points != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                               input logic [CFG_DATA_W-1:0] step,
                               input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy,
                               input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SAMPLE_STEP, step);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(9))
      0, 1:    return '0;
      2:       return 16'hFFFF;
      3:       return 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_side();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'($urandom_range(4097, 65535));
      default: return 16'($urandom_range(2, 24));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_focal();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'($urandom_range(1, 16));
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(16, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 400));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] step;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_wdata = '0;
    random_sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setup: origin pixel sampled, neighbors skipped, zero depth
    send_depth(16'hFFFF);
    send_depth(16'd1);
    send_depth('0);

    // zero step and zero focal length, center at the far edge: negative clamp
    apply_setting(16'd3, 16'd2, '0, '0, 16'hFFFF, 16'hFFFF, '0);
    send_depth(16'hFFFF);
    send_depth(16'd1);
    send_depth(16'h5555);
    send_depth(16'hAAAA);
    send_depth('0);
    send_depth(16'hFFFF);

    // image shrinks mid-frame, then zero sizes with the largest step
    apply_setting(16'd8, 16'd8, 16'd1, 16'd16, 16'd16, 16'd16, 16'd16);
    repeat (5) send_depth(16'($urandom_range(1, 65535)));
    apply_setting(16'd2, 16'd2, 16'd1, 16'd16, 16'd16, 16'd16, 16'd16);
    repeat (3) send_depth(16'($urandom_range(1, 65535)));
    apply_setting('0, '0, 16'd127, 16'd160, 16'd160, 16'd8, 16'd8);
    send_depth(16'h8000);
    send_depth(16'h7FFF);

    random_sent = 0;

    // long rows with tiny focal length and centers at zero: positive clamp
    apply_setting(16'd4096, 16'd3, 16'($urandom_range(1, 3)), 16'($urandom_range(0, 2)),
                  16'($urandom_range(0, 2)), '0, '0);
    repeat (300) send_depth(pick_depth());

    // receiver holds off while every pixel yields a point: block fills up
    apply_setting(16'd5, 16'd5, 16'd1, pick_focal(), pick_focal(), pick_center(), pick_center());
    @(posedge clk);
    hold_req = ~hold_req;
    repeat (40) send_depth(16'($urandom_range(1, 65535)));

    // random setups, throttle mode follows progress
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(7))
        0:       step = '0;
        1:       step = 16'($urandom_range(64, 127));
        2:       step = 16'd64;
        default: step = 16'($urandom_range(1, 4));
      endcase
      apply_setting(pick_side(), pick_side(), step, pick_focal(), pick_focal(),
                    pick_center(), pick_center());
      if (random_sent < RANDOM_ITEMS / 3) idle_mode = MODE_RX_SLOW;
      else if (random_sent < 2 * RANDOM_ITEMS / 3) idle_mode = MODE_TX_SLOW;
      else idle_mode = MODE_FULL;
      repeat ($urandom_range(30, 120)) send_depth(pick_depth());
    end

    wait_idle();
    if (fail_count == 0 && pending_points == 0) begin
      $display("tb_depth_pixel_backprojection_top passed");
    end else begin
      $display("tb_depth_pixel_backprojection_top failed");
    end
    $finish;
  end

endmodule
